>>> hw/rtl/nqbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nqbs_pkg;

  localparam int unsigned MaxSize = 8;
  localparam int unsigned RowW    = $clog2(MaxSize);
  localparam int unsigned ColW    = 4;
  localparam int unsigned SizeW   = 4;
  localparam int unsigned PlaceW  = RowW * MaxSize;
  localparam int unsigned CountW  = 8;

  typedef logic [ColW-1:0]   col_t;
  typedef logic [RowW-1:0]   row_idx_t;
  typedef logic [SizeW-1:0]  size_t;
  typedef logic [PlaceW-1:0] placement_t;
  typedef logic [CountW-1:0] count_t;

  localparam col_t  Untried   = col_t'(4'hF);
  localparam size_t SizeReset = size_t'(MaxSize);

endpackage

`default_nettype wire

>>> hw/rtl/n_queens_backtrack_search.sv
`timescale 1ns / 1ps
`default_nettype none

// N-queens backtracking search, one solution per request.
// Command channel: raise start with restart; the item is taken at a rising edge
// where start is high and busy is low. restart = 1 begins a fresh search,
// restart = 0 resumes after the last placement returned.
// Result channel: strobe_o is high for one cycle with found_o, placement_o
// (three bits per row, row zero low) and solution_number_o. found_o = 0 means
// the search is exhausted; further resumes repeat that answer until a restart.
// Configuration: cfg_we_i writes cfg_wdata_i into the board size. It must be
// written only while idle; the block itself does not enforce this. The column
// increment and the row check share one column read port. A request steps
// through column increments, checks against each earlier row and row descents,
// as the column advance and row-by-row diagonal check demand. busy stays high
// until the result has been given and the search has moved past it.
// Reset: board size 8, search cleared, as a fresh restart.
// The receiver cannot stall: each result is shown for exactly one cycle.
module n_queens_backtrack_search (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire nqbs_pkg::size_t     cfg_wdata_i,
  input  wire                      start,
  input  wire                      restart_i,
  output logic                     busy,
  output logic                     strobe_o,
  output logic                     found_o,
  output nqbs_pkg::placement_t     placement_o,
  output nqbs_pkg::count_t         solution_number_o
);
  import nqbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_INC,
    ST_CHECK
  } state_e;

  state_e     state_q, state_d;
  size_t      board_size_q, board_size_d;
  size_t      n_q, n_d;
  col_t       rc_q [MaxSize];
  col_t       rc_d [MaxSize];
  size_t      cur_q, cur_d;
  row_idx_t   i_q, i_d;
  col_t       col_q, col_d;
  logic       done_q, done_d;
  logic       ret_idle_q, ret_idle_d;
  count_t     sol_q, sol_d;
  logic       strobe_q, strobe_d;
  logic       found_q, found_d;
  placement_t place_q, place_d;
  count_t     num_q, num_d;

  size_t      size_use;
  row_idx_t   rd_idx;
  col_t       rd_col;
  col_t       inc_col;
  col_t       diff;
  size_t      row_dist;
  placement_t packed_place;
  logic       at_end;

  always_comb begin
    if (board_size_q == '0) begin
      size_use = size_t'(1);
    end else if (board_size_q > size_t'(MaxSize)) begin
      size_use = size_t'(MaxSize);
    end else begin
      size_use = board_size_q;
    end
  end

  assign rd_idx   = (state_q == ST_CHECK) ? i_q : cur_q[RowW-1:0];
  assign rd_col   = rc_q[rd_idx];
  assign inc_col  = rd_col + col_t'(1);
  assign diff     = (rd_col > col_q) ? (rd_col - col_q) : (col_q - rd_col);
  assign row_dist = cur_q - size_t'(i_q);

  always_comb begin
    packed_place = '0;
    for (int r = 0; r < MaxSize; r++) begin
      if (size_t'(r) < n_q) begin
        packed_place[r*RowW +: RowW] = rc_q[r][RowW-1:0];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    board_size_d = board_size_q;
    n_d          = n_q;
    rc_d         = rc_q;
    cur_d        = cur_q;
    i_d          = i_q;
    col_d        = col_q;
    done_d       = done_q;
    ret_idle_d   = ret_idle_q;
    sol_d        = sol_q;
    strobe_d     = 1'b0;
    found_d      = found_q;
    place_d      = place_q;
    num_d        = num_q;
    at_end       = 1'b0;

    if (cfg_we_i) begin
      board_size_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d     = size_use;
          state_d = ST_LOOP;
          if (restart_i) begin
            for (int r = 0; r < MaxSize; r++) begin
              rc_d[r] = '0;
            end
            cur_d  = '0;
            done_d = 1'b0;
            sol_d  = '0;
          end
        end
      end
      ST_LOOP: begin
        if (done_q || (cur_q >= n_q)) begin
          done_d   = 1'b1;
          strobe_d = 1'b1;
          found_d  = 1'b0;
          place_d  = '0;
          num_d    = sol_q;
          state_d  = ST_IDLE;
        end else if (cur_q == n_q - size_t'(1)) begin
          sol_d    = sol_q + count_t'(1);
          strobe_d = 1'b1;
          found_d  = 1'b1;
          place_d  = packed_place;
          num_d    = sol_q + count_t'(1);
          if (cur_q == '0) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cur_d      = cur_q - size_t'(1);
            ret_idle_d = 1'b1;
            state_d    = ST_INC;
          end
        end else begin
          cur_d = cur_q + size_t'(1);
          rc_d[cur_q[RowW-1:0] + row_idx_t'(1)] = Untried;
          ret_idle_d = 1'b0;
          state_d    = ST_INC;
        end
      end
      ST_INC: begin
        rc_d[cur_q[RowW-1:0]] = inc_col;
        if (size_t'(inc_col) >= n_q) begin
          if (cur_q == '0) begin
            done_d = 1'b1;
            at_end = 1'b1;
          end else begin
            cur_d = cur_q - size_t'(1);
          end
        end else if (cur_q == '0) begin
          at_end = 1'b1;
        end else begin
          i_d     = '0;
          col_d   = inc_col;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((diff == '0) || (size_t'(diff) == row_dist)) begin
          state_d = ST_INC;
        end else if (size_t'(i_q) == cur_q - size_t'(1)) begin
          at_end = 1'b1;
        end else begin
          i_d = i_q + row_idx_t'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (at_end) begin
      state_d = ret_idle_q ? ST_IDLE : ST_LOOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      board_size_q <= SizeReset;
      n_q          <= SizeReset;
      for (int r = 0; r < MaxSize; r++) begin
        rc_q[r] <= '0;
      end
      cur_q        <= '0;
      i_q          <= '0;
      col_q        <= '0;
      done_q       <= 1'b0;
      ret_idle_q   <= 1'b0;
      sol_q        <= '0;
      strobe_q     <= 1'b0;
      found_q      <= 1'b0;
      place_q      <= '0;
      num_q        <= '0;
    end else begin
      state_q      <= state_d;
      board_size_q <= board_size_d;
      n_q          <= n_d;
      rc_q         <= rc_d;
      cur_q        <= cur_d;
      i_q          <= i_d;
      col_q        <= col_d;
      done_q       <= done_d;
      ret_idle_q   <= ret_idle_d;
      sol_q        <= sol_d;
      strobe_q     <= strobe_d;
      found_q      <= found_d;
      place_q      <= place_d;
      num_q        <= num_d;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign strobe_o          = strobe_q;
  assign found_o           = found_q;
  assign placement_o       = place_q;
  assign solution_number_o = num_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  a_strobe_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result given without an item at work");

  a_found_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && found_o) |-> (solution_number_o != '0))
    else $error("solution given with zero count");

  a_one_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("two results for one item");

endmodule

`default_nettype wire

>>> tb/n_queens_solution_checker.sv
`timescale 1ns / 1ps

module n_queens_solution_checker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  nqbs_pkg::size_t      cfg_wdata_i,
  input  wire                  start_i,
  input  wire                  restart_i,
  input  wire                  busy_i,
  input  wire                  strobe_i,
  input  wire                  found_i,
  input  nqbs_pkg::placement_t placement_i,
  input  nqbs_pkg::count_t     solution_number_i,
  output int unsigned          failures_o,
  output int unsigned          pending_o
);
  import nqbs_pkg::*;

  typedef struct packed {
    logic       found;
    placement_t placement;
    count_t     number;
  } solution_t;

  size_t       board_size;
  col_t        cols [MaxSize];
  logic [3:0]  depth;
  logic        exhausted;
  count_t      seen;
  solution_t   expected_solutions [$];
  solution_t   predicted;
  solution_t   oldest;
  int unsigned mismatches;

  assign failures_o = mismatches;
  assign pending_o  = expected_solutions.size();

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  function automatic int unsigned size_in_use();
    int unsigned n;
    n = 32'(board_size);
    if (n == 0) n = 1;
    if (n > MaxSize) n = MaxSize;
    return n;
  endfunction

  function automatic bit column_clear(input int unsigned row);
    int unsigned i;
    int unsigned col;
    int unsigned other;
    int unsigned diff;
    col = 32'(cols[row[RowW-1:0]]);
    for (i = 0; i < row; i++) begin
      other = 32'(cols[i[RowW-1:0]]);
      diff  = (other > col) ? other - col : col - other;
      if (diff == 0 || diff == row - i) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_search();
    for (int i = 0; i < MaxSize; i++) cols[i[RowW-1:0]] = '0;
    depth     = '0;
    exhausted = 1'b0;
    seen      = '0;
  endtask

  // advance the current row, backing up when its columns run out
  task automatic advance_column(input int unsigned n);
    int unsigned r;
    bit placed;
    placed = 1'b0;
    while (!exhausted && !placed) begin
      r                  = 32'(depth);
      cols[r[RowW-1:0]] = cols[r[RowW-1:0]] + 1'b1;
      if (cols[r[RowW-1:0]] >= n) begin
        if (r == 0) exhausted = 1'b1;
        else depth = depth - 1'b1;
      end else if (column_clear(r)) begin
        placed = 1'b1;
      end
    end
  endtask

  task automatic next_solution(input logic fresh, output solution_t sol);
    int unsigned n;
    bit settled;
    n   = size_in_use();
    sol = '0;
    if (fresh) clear_search();
    settled = 1'b0;
    while (!settled) begin
      if (!exhausted && depth >= n) exhausted = 1'b1;
      if (exhausted) begin
        sol.found     = 1'b0;
        sol.placement = '0;
        sol.number    = seen;
        settled       = 1'b1;
      end else if (depth == n - 1) begin
        for (int r = 0; r < n; r++) sol.placement[3*r +: 3] = cols[r[RowW-1:0]][2:0];
        seen       = seen + 1'b1;
        sol.found  = 1'b1;
        sol.number = seen;
        if (depth == 0) begin
          exhausted = 1'b1;
        end else begin
          depth = depth - 1'b1;
          advance_column(n);
        end
        settled = 1'b1;
      end else begin
        depth                   = depth + 1'b1;
        cols[depth[RowW-1:0]] = Untried;
        advance_column(n);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size = SizeReset;
      clear_search();
      expected_solutions.delete();
      mismatches = 0;
    end else begin
      if (strobe_i) begin
        if (expected_solutions.size() == 0) begin
          report_mismatch("unrequested result", 0, {found_i, placement_i, solution_number_i});
        end else begin
          oldest = expected_solutions.pop_front();
          if (found_i !== oldest.found)
            report_mismatch("found", oldest.found, found_i);
          if (placement_i !== oldest.placement)
            report_mismatch("placement", oldest.placement, placement_i);
          if (solution_number_i !== oldest.number)
            report_mismatch("solution_number", oldest.number, solution_number_i);
        end
      end
      if (start_i && !busy_i) begin
        next_solution(restart_i, predicted);
        expected_solutions.push_back(predicted);
      end
      if (cfg_we_i) board_size = cfg_wdata_i;
    end
  end

endmodule

>>> tb/n_queens_backtrack_search_tb.sv
`timescale 1ns / 1ps

module n_queens_backtrack_search_tb;
  import nqbs_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  size_t       cfg_wdata_i;
  logic        start;
  logic        restart_i;
  logic        busy;
  logic        strobe_o;
  logic        found_o;
  placement_t  placement_o;
  count_t      solution_number_o;
  int unsigned failures;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned phase;
  int unsigned phase_items;
  int unsigned pick;

  n_queens_backtrack_search i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .restart_i         (restart_i),
    .busy              (busy),
    .strobe_o          (strobe_o),
    .found_o           (found_o),
    .placement_o       (placement_o),
    .solution_number_o (solution_number_o)
  );

  n_queens_solution_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start),
    .restart_i         (restart_i),
    .busy_i            (busy),
    .strobe_i          (strobe_o),
    .found_i           (found_o),
    .placement_i       (placement_o),
    .solution_number_i (solution_number_o),
    .failures_o        (failures),
    .pending_o         (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic fresh);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start     = 1'b1;
    restart_i = fresh;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // hold until every result is back and the search has settled
  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
  endtask

  task automatic set_board_size(input size_t value);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start       = 1'b0;
    restart_i   = 1'b0;
    idle_pct    = 0;
    items_sent  = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    set_board_size(size_t'(1));
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    set_board_size(size_t'(0));
    send_item(1'b1);
    send_item(1'b0);
    set_board_size(size_t'(2));
    send_item(1'b1);
    set_board_size(size_t'(3));
    send_item(1'b1);
    set_board_size(size_t'(4));
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);
    set_board_size(size_t'(15));
    send_item(1'b1);
    send_item(1'b0);
    set_board_size(size_t'(8));
    send_item(1'b1);
    send_item(1'b0);
    set_board_size(size_t'(5));
    send_item(1'b0);
    send_item(1'b1);
    set_board_size(size_t'(7));
    send_item(1'b0);

    phase = 0;
    while (items_sent < 140) begin
      pick = $urandom_range(9);
      if (pick <= 6) set_board_size(size_t'($urandom_range(1, 6)));
      else if (pick == 7) set_board_size(size_t'($urandom_range(7, 8)));
      else if (pick == 8) set_board_size(size_t'($urandom_range(9, 15)));
      else set_board_size(size_t'(0));
      case (phase % 4)
        1: begin
          idle_pct = 63;
        end
        3: begin
          idle_pct = 12;
        end
        default: begin
          idle_pct = 0;
        end
      endcase
      phase_items = $urandom_range(6, 14);
      send_item(logic'($urandom_range(1)));
      for (int i = 1; i < phase_items && items_sent < 140; i++) begin
        if ($urandom_range(19) == 0) wait_idle();
        send_item($urandom_range(9) == 0);
      end
      phase++;
    end

    wait_idle();
    repeat (64) @(posedge clk_i);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
